/* rtl/bmd_pkg.sv */
// ----------------------------------------------------------------------------
// bmd_pkg: shared types and constants for the bridge max deviation block
// Ring geometry, datapath widths, sequencer states and the scan control
// bundle handed from the sequencer to the deviation datapath.
// ----------------------------------------------------------------------------
package bmd_pkg;

  localparam int RING_DEPTH = 256;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int CNT_W      = ADDR_W + 1;   // holds 0..RING_DEPTH
  localparam int PRICE_W    = 32;
  localparam int DEV_W      = 32;
  localparam int WIN_W      = 8;
  localparam int DIFF_W     = PRICE_W + 1;  // pn - p0 and its magnitude
  localparam int BR_W       = PRICE_W + 2;  // bridge accumulator
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(120);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_P0,
    ST_DIV,
    ST_SCAN,
    ST_DONE
  } bmd_state_t;

  // bridge step parameters for one scan
  typedef struct packed {
    logic                neg;
    logic [DIFF_W-1:0]   quot;
    logic [CNT_W-1:0]    rem;
    logic [CNT_W-1:0]    n;
    logic [PRICE_W-1:0]  p0;
  } scan_ctl_t;

  // window span (n - 1) from the updated fill count and the window register
  function automatic logic [CNT_W-1:0] calc_span(logic [CNT_W-1:0] seen_n,
                                                 logic [WIN_W-1:0] win);
    logic [31:0] s;
    logic [31:0] w;
    s = 32'(seen_n) - 32'd1;
    w = 32'(win);
    if (w > 32'(RING_DEPTH - 1)) w = 32'(RING_DEPTH - 1);
    if (s > w) s = w;
    return s[CNT_W-1:0];
  endfunction

endpackage

/* rtl/bmd_ring.sv */
// ----------------------------------------------------------------------------
// bmd_ring: price ring storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bmd_ring
  import bmd_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [PRICE_W-1:0] wdata,
  input  logic               re,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [PRICE_W-1:0] rdata
);

  logic [PRICE_W-1:0] mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/bmd_div.sv */
// ----------------------------------------------------------------------------
// bmd_div: iterative restoring divider
// One quotient bit per cycle; done pulses once the last bit is in.
// ----------------------------------------------------------------------------
module bmd_div
  import bmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIFF_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [DIFF_W-1:0] quot,
  output logic [CNT_W-1:0]  rem
);

  localparam int STEP_W = $clog2(DIFF_W + 1);

  logic [STEP_W-1:0] steps;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem, quot[DIFF_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        steps <= STEP_W'(DIFF_W);
      end else if (steps != '0) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (steps != '0) begin
      // shift in the next dividend bit, subtract when it fits
      quot <= {quot[DIFF_W-2:0], fits};
      rem  <= fits ? CNT_W'(trial - {1'b0, dvs}) : trial[CNT_W-1:0];
    end
  end

endmodule

/* rtl/bmd_scan.sv */
// ----------------------------------------------------------------------------
// bmd_scan: bridge walk and running maximum
// Step the bridge line by quotient plus remainder carry per entry, register
// the absolute deviation, then fold it into the running maximum.
// ----------------------------------------------------------------------------
module bmd_scan
  import bmd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  scan_ctl_t          ctl,
  input  logic               dv,
  input  logic [PRICE_W-1:0] data,
  output logic               busy,
  output logic [DEV_W-1:0]   best
);

  scan_ctl_t          cur;
  logic [BR_W-1:0]    bridge;
  logic [CNT_W-1:0]   racc;
  logic [CNT_W:0]     rsum;
  logic               carry;
  logic [BR_W-1:0]    inc;
  logic [BR_W-1:0]    dev;
  logic [DEV_W-1:0]   absdev;
  logic               v1;

  assign rsum  = {1'b0, racc} + {1'b0, cur.rem};
  assign carry = rsum >= {1'b0, cur.n};
  assign inc   = BR_W'(cur.quot) + BR_W'(carry);
  assign dev   = BR_W'(signed'(data)) - bridge;
  assign busy  = v1;

  always_ff @(posedge clk) begin
    if (start) begin
      cur    <= ctl;
      bridge <= BR_W'(signed'(ctl.p0));
      racc   <= '0;
    end else if (dv) begin
      // advance the bridge to the next entry
      racc   <= carry ? CNT_W'(rsum - {1'b0, cur.n}) : rsum[CNT_W-1:0];
      bridge <= cur.neg ? bridge - inc : bridge + inc;
    end
  end

  always_ff @(posedge clk) begin
    if (dv) begin
      absdev <= dev[BR_W-1] ? DEV_W'(-dev) : dev[DEV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= dv && !start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      best <= '0;
    end else if (v1 && absdev > best) begin
      best <= absdev;
    end
  end

endmodule

/* rtl/bridge_max_deviation.sv */
// ----------------------------------------------------------------------------
// bridge_max_deviation: largest distance of window prices from a bridge line
// Sequencer around the price ring, the divider and the bridge scan datapath.
// ----------------------------------------------------------------------------
// Sequence: CALC reads the oldest window price (a window of one price goes
//   straight to DONE), P0 starts the divider, DIV waits for it, SCAN reads
//   the n window entries (n = window length, 1..256), DONE loads the result.
// Throughput: one item at a time; the input stalls until the result is in
//   the output register.
// Reset: synchronous; clears pointer, fill count and handshake; window 120.
// ----------------------------------------------------------------------------
module bridge_max_deviation
  import bmd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PRICE_W-1:0] price,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DEV_W-1:0]   max_deviation,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [WIN_W-1:0]   window_bars
);

  bmd_state_t         state, state_next;
  logic [WIN_W-1:0]   win;
  logic [ADDR_W-1:0]  wp;
  logic [CNT_W-1:0]   seen;
  logic [CNT_W-1:0]   seen_upd;
  logic [CNT_W-1:0]   span_upd;
  logic [CNT_W-1:0]   n;
  logic [ADDR_W-1:0]  base;
  logic [PRICE_W-1:0] pn;
  logic [PRICE_W-1:0] p0;
  logic [CNT_W-1:0]   rk;
  logic               rdv;
  logic               in_xfer;
  logic               out_xfer;

  // datapath hookups driven by the sequencer
  logic               ring_re;
  logic [ADDR_W-1:0]  ring_raddr;
  logic [PRICE_W-1:0] ring_rdata;
  logic               div_start;
  logic               div_done;
  logic [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]  mag;
  logic [DIFF_W-1:0]  div_quot;
  logic [CNT_W-1:0]   div_rem;
  logic               neg;
  logic               scan_start;
  logic               scan_busy;
  scan_ctl_t          scan_ctl;
  logic [DEV_W-1:0]   scan_best;
  logic               load_out;

  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign cfg_ready = 1'b1;
  assign in_stall  = state != ST_IDLE;

  // updated fill count and window span for the item being taken
  assign seen_upd = (seen < CNT_W'(RING_DEPTH)) ? seen + 1'b1 : seen;
  assign span_upd = calc_span(seen_upd, win);

  // window register
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= WIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      win <= window_bars;
    end
  end

  // write pointer and fill count advance on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      seen <= '0;
    end else if (in_xfer) begin
      wp   <= wp + 1'b1;
      seen <= seen_upd;
    end
  end

  // per-item payload: newest price, window length, oldest slot
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pn   <= price;
      n    <= span_upd + 1'b1;
      base <= wp - span_upd[ADDR_W-1:0];
    end
  end

  bmd_ring u_ring (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (wp),
    .wdata (price),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // slope sign and magnitude from the oldest price just read back
  assign diff = DIFF_W'(signed'(pn)) - DIFF_W'(signed'(ring_rdata));
  assign neg  = diff[DIFF_W-1];
  assign mag  = neg ? -diff : diff;

  // hold p0 and the slope sign for the scan
  logic neg_q;
  always_ff @(posedge clk) begin
    if (state == ST_P0) begin
      p0    <= ring_rdata;
      neg_q <= neg;
    end
  end

  bmd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (n),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign scan_ctl = '{neg: neg_q, quot: div_quot, rem: div_rem, n: n, p0: p0};

  bmd_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (scan_start),
    .ctl   (scan_ctl),
    .dv    (rdv),
    .data  (ring_rdata),
    .busy  (scan_busy),
    .best  (scan_best)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and sequencer controls
  always_comb begin
    state_next = state;
    ring_re    = 1'b0;
    ring_raddr = base + rk[ADDR_W-1:0];
    div_start  = 1'b0;
    scan_start = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_xfer) state_next = ST_CALC;
      end
      ST_CALC: begin
        // a lone price deviates by nothing; skip straight to the result
        if (n == CNT_W'(1)) begin
          state_next = ST_DONE;
        end else begin
          ring_re    = 1'b1;
          ring_raddr = base;
          state_next = ST_P0;
        end
      end
      ST_P0: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          scan_start = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rk < n) begin
          ring_re = 1'b1;
        end else if (!rdv && !scan_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // scan read counter and read-data valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rk  <= '0;
      rdv <= 1'b0;
    end else begin
      rdv <= (state == ST_SCAN) && ring_re;
      if (scan_start) begin
        rk <= '0;
      end else if ((state == ST_SCAN) && ring_re) begin
        rk <= rk + 1'b1;
      end
    end
  end

  // output register: load a finished result, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      max_deviation <= (n == CNT_W'(1)) ? '0 : scan_best;
    end
  end

  // the read counter never runs past the window
  a_rk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rk <= n))
    else $error("scan read counter beyond window");

  // the divider finishes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider done outside wait state");

  // fill count saturates at the ring depth
  a_seen_sat: assert property (@(posedge clk) disable iff (rst)
    seen <= CNT_W'(RING_DEPTH))
    else $error("fill count overflow");

  // an accepted item closes the input until its result is out
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> in_stall)
    else $error("input open right after a transfer");

  // ring data arrives only during the scan
  a_rdv_scan: assert property (@(posedge clk) disable iff (rst)
    rdv |-> (state == ST_SCAN))
    else $error("ring data outside scan");

endmodule
